>>> hw/rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescape block.
// Used by the front decoder, the result queue, the output serializer and the checker.
`timescale 1ns / 1ps

package jsu_pkg;

	// Most result items one input item can cause
	localparam int MAX_RES = 4;
	localparam int CNT_W = $clog2(MAX_RES + 1);
	localparam int IDX_W = $clog2(MAX_RES);

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Characters the decoder looks for
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// Code point used for a broken surrogate pair
	localparam logic [20:0] CP_REPLACE = 21'h00FFFD;

	typedef enum logic [2:0] {
		KIND_BYTE         = 3'd0,
		KIND_CLOSED       = 3'd1,
		KIND_EXPECT_QUOTE = 3'd2,
		KIND_BAD_ESCAPE   = 3'd3,
		KIND_BAD_UNICODE  = 3'd4,
		KIND_UNTERMINATED = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_BODY    = 3'd1,
		MODE_ESC     = 3'd2,
		MODE_HEX     = 3'd3,
		MODE_HIGH    = 3'd4,
		MODE_HIGH_BS = 3'd5,
		MODE_LOW_HEX = 3'd6
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} result_t;

	// All results of one input item, first result in res[0]
	typedef struct packed {
		logic [CNT_W-1:0]          cnt;
		result_t [MAX_RES-1:0]     res;
	} bundle_t;

	// Queue status seen by the top-level input gating and the back
	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

endpackage

>>> hw/rtl/jsu_front.sv
// Front decoder: accepts text bytes, runs the escape state machine and
// builds the result bundle of each item. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic        end_flag,
	output logic        push,
	output bundle_t     bundle
);

	mode_t       mode_q, mode_d;
	logic [15:0] hex_q, hex_d;
	logic [1:0]  dcnt_q, dcnt_d;
	logic [9:0]  held_q, held_d;

	// Body and escape handling of the current byte
	logic    body_tv, esc_tv;
	result_t body_t, esc_t;
	mode_t   body_mode, esc_mode;

	// Hex digit decode
	logic        dig_ok;
	logic [3:0]  dig_val;
	logic [15:0] hex_new;
	logic        fourth;

	// Encoder input and tail result
	logic        enc_v;
	logic [20:0] enc_cp;
	logic [CNT_W-1:0] enc_len;
	logic [CNT_W-1:0] enc_len_eff;
	logic [7:0]  enc_b [MAX_RES];
	logic        tail_v;
	result_t     tail;

	// Classify the byte as body text, escape letter and hex digit
	always_comb begin
		body_tv   = 1'b1;
		body_t    = '{data: in_byte, kind: KIND_BYTE, last: 1'b0};
		body_mode = MODE_BODY;
		if (in_byte == CH_QUOTE) begin
			body_t    = '{data: 8'h00, kind: KIND_CLOSED, last: 1'b1};
			body_mode = MODE_IDLE;
		end else if (in_byte == CH_BSLASH) begin
			body_tv   = 1'b0;
			body_mode = MODE_ESC;
		end

		esc_tv   = 1'b1;
		esc_mode = MODE_BODY;
		esc_t    = '{data: in_byte, kind: KIND_BYTE, last: 1'b0};
		unique case (in_byte)
			CH_QUOTE, CH_BSLASH, CH_SLASH: esc_t.data = in_byte;
			CH_B: esc_t.data = 8'h08;
			CH_F: esc_t.data = 8'h0C;
			CH_N: esc_t.data = 8'h0A;
			CH_R: esc_t.data = 8'h0D;
			CH_T: esc_t.data = 8'h09;
			CH_U: begin
				esc_tv   = 1'b0;
				esc_mode = MODE_HEX;
			end
			default: begin
				esc_t    = '{data: 8'h00, kind: KIND_BAD_ESCAPE, last: 1'b1};
				esc_mode = MODE_IDLE;
			end
		endcase

		dig_ok  = 1'b1;
		dig_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39)
			dig_val = 4'(in_byte - 8'h30);
		else if (in_byte >= 8'h61 && in_byte <= 8'h66)
			dig_val = 4'(in_byte - 8'h57);
		else if (in_byte >= 8'h41 && in_byte <= 8'h46)
			dig_val = 4'(in_byte - 8'h37);
		else
			dig_ok = 1'b0;
		hex_new = {hex_q[11:0], dig_val};
		fourth  = (dcnt_q == 2'd3);
	end

	// Next state and the results of this item
	always_comb begin
		mode_d = mode_q;
		hex_d  = hex_q;
		dcnt_d = dcnt_q;
		held_d = held_q;
		enc_v  = 1'b0;
		enc_cp = CP_REPLACE;
		tail_v = 1'b0;
		tail   = '{data: 8'h00, kind: KIND_BYTE, last: 1'b0};
		unique case (mode_q)
			MODE_BODY: begin
				if (end_flag) begin
					tail_v = 1'b1;
					tail   = '{data: 8'h00, kind: KIND_UNTERMINATED, last: 1'b1};
					mode_d = MODE_IDLE;
				end else begin
					tail_v = body_tv;
					tail   = body_t;
					mode_d = body_mode;
				end
			end
			MODE_ESC: begin
				if (end_flag) begin
					tail_v = 1'b1;
					tail   = '{data: 8'h00, kind: KIND_UNTERMINATED, last: 1'b1};
					mode_d = MODE_IDLE;
				end else begin
					tail_v = esc_tv;
					tail   = esc_t;
					mode_d = esc_mode;
					if (esc_mode == MODE_HEX) begin
						hex_d  = 16'h0000;
						dcnt_d = 2'd0;
					end
				end
			end
			MODE_HEX, MODE_LOW_HEX: begin
				if (end_flag || !dig_ok) begin
					tail_v = 1'b1;
					tail   = '{data: 8'h00, kind: KIND_BAD_UNICODE, last: 1'b1};
					mode_d = MODE_IDLE;
				end else begin
					hex_d  = hex_new;
					dcnt_d = dcnt_q + 2'd1;
					if (fourth) begin
						mode_d = MODE_BODY;
						enc_v  = 1'b1;
						if (mode_q == MODE_HEX) begin
							if (hex_new >= 16'hD800 && hex_new <= 16'hDBFF) begin
								held_d = hex_new[9:0];
								mode_d = MODE_HIGH;
								enc_v  = 1'b0;
							end else begin
								enc_cp = {5'd0, hex_new};
							end
						end else if (hex_new >= 16'hDC00 && hex_new <= 16'hDFFF) begin
							enc_cp = 21'h010000 + {1'b0, held_q, hex_new[9:0]};
						end
					end
				end
			end
			MODE_HIGH: begin
				if (end_flag) begin
					enc_v  = 1'b1;
					tail_v = 1'b1;
					tail   = '{data: 8'h00, kind: KIND_UNTERMINATED, last: 1'b1};
					mode_d = MODE_IDLE;
				end else if (in_byte == CH_BSLASH) begin
					mode_d = MODE_HIGH_BS;
				end else begin
					enc_v  = 1'b1;
					tail_v = body_tv;
					tail   = body_t;
					mode_d = body_mode;
				end
			end
			MODE_HIGH_BS: begin
				if (end_flag) begin
					enc_v  = 1'b1;
					tail_v = 1'b1;
					tail   = '{data: 8'h00, kind: KIND_UNTERMINATED, last: 1'b1};
					mode_d = MODE_IDLE;
				end else if (in_byte == CH_U) begin
					hex_d  = 16'h0000;
					dcnt_d = 2'd0;
					mode_d = MODE_LOW_HEX;
				end else begin
					enc_v  = 1'b1;
					tail_v = esc_tv;
					tail   = esc_t;
					mode_d = esc_mode;
				end
			end
			default: begin
				if (!end_flag && in_byte == CH_QUOTE) begin
					mode_d = MODE_BODY;
				end else begin
					tail_v = 1'b1;
					tail   = '{data: 8'h00, kind: KIND_EXPECT_QUOTE, last: 1'b1};
					mode_d = MODE_IDLE;
				end
			end
		endcase
	end

	// Encode the code point as UTF-8
	always_comb begin
		for (int i = 0; i < MAX_RES; i++)
			enc_b[i] = 8'h00;
		if (enc_cp <= 21'h00007F) begin
			enc_len  = CNT_W'(1);
			enc_b[0] = enc_cp[7:0];
		end else if (enc_cp <= 21'h0007FF) begin
			enc_len  = CNT_W'(2);
			enc_b[0] = {3'b110, enc_cp[10:6]};
			enc_b[1] = {2'b10, enc_cp[5:0]};
		end else if (enc_cp <= 21'h00FFFF) begin
			enc_len  = CNT_W'(3);
			enc_b[0] = {4'b1110, enc_cp[15:12]};
			enc_b[1] = {2'b10, enc_cp[11:6]};
			enc_b[2] = {2'b10, enc_cp[5:0]};
		end else begin
			enc_len  = CNT_W'(4);
			enc_b[0] = {5'b11110, enc_cp[20:18]};
			enc_b[1] = {2'b10, enc_cp[17:12]};
			enc_b[2] = {2'b10, enc_cp[11:6]};
			enc_b[3] = {2'b10, enc_cp[5:0]};
		end
		enc_len_eff = enc_v ? enc_len : '0;
	end

	// Pack encoded bytes, then the tail result, into the bundle
	always_comb begin
		bundle.cnt = enc_len_eff + CNT_W'(tail_v);
		for (int i = 0; i < MAX_RES; i++) begin
			bundle.res[i] = '{data: 8'h00, kind: KIND_BYTE, last: 1'b0};
			if (CNT_W'(i) < enc_len_eff)
				bundle.res[i].data = enc_b[i];
			else if (tail_v && CNT_W'(i) == enc_len_eff)
				bundle.res[i] = tail;
		end
		push = accept && (bundle.cnt != '0);
	end

	// Advance decoder state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hex_q  <= 16'h0000;
			dcnt_q <= 2'd0;
			held_q <= 10'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
			dcnt_q <= dcnt_d;
			held_q <= held_d;
		end
	end

endmodule

>>> hw/rtl/jsu_queue.sv
// Bundle queue between the front decoder and the output serializer.
// Depends on jsu_pkg for the bundle type.
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bundle_t     push_data,
	input  logic        pop,
	output bundle_t     head,
	output queue_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == FILL_W'(DEPTH));

	// Store pushed bundles
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/jsu_back.sv
// Output serializer: unpacks queued bundles into one result item per cycle while
// out_stall is low, behind an output register. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  queue_stat_t stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [2:0]  kind,
	output logic        last
);

	bundle_t          cur_q;
	logic             cur_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	result_t          out_q;
	logic             load_out;
	logic             last_elem;

	assign load_out  = cur_valid_q && (!out_valid_q || !out_stall);
	assign last_elem = (CNT_W'(idx_q) + CNT_W'(1)) == cur_q.cnt;
	assign pop       = !stat.empty && (!cur_valid_q || (load_out && last_elem));

	assign out_valid = out_valid_q;
	assign out_byte  = out_q.data;
	assign kind      = out_q.kind;
	assign last      = out_q.last;

	// Load the output register from the current bundle and the current bundle from the queue head
	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= cur_q.res[idx_q];
		if (pop)
			cur_q <= head;
	end

	// Step through the bundle and refill from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (load_out && last_elem) begin
				cur_valid_q <= 1'b0;
			end else if (load_out) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/json_string_unescape_utf8.sv
// JSON string unescape top level: front decoder, bundle queue and output serializer.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
`timescale 1ns / 1ps

// Feed a JSON string literal one byte per item, opening quote first; end_flag marks end
// of text. The block takes one item per cycle while its bundle queue (QUEUE_DEPTH
// entries) has room and hands out one result item per cycle from its output register
// while out_stall is low; an item that decodes to n results (at most four: a surrogate
// pair or a U+FFFD followed by one more result) leaves as n results; text that decodes
// byte for byte runs at one item per cycle. Results pass through the queue, the current
// bundle register and the output register. A close or error result carries last, after
// which the block waits for a new opening quote. There is no startup sweep after reset.
module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_flag,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       last
);

	logic        accept;
	logic        push;
	logic        pop;
	bundle_t     push_data;
	bundle_t     head;
	queue_stat_t stat;

	// Hold input while the queue is full
	assign in_stall = stat.full;
	assign accept   = in_valid && !stat.full;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.end_flag (end_flag),
		.push     (push),
		.bundle   (push_data)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

endmodule

>>> hw/rtl/jsu_checker.sv
// Port-level checks for the JSON string unescape block, bound to its top level.
// Depends on jsu_pkg for the result kind codes.
`timescale 1ns / 1ps

module jsu_checker import jsu_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       end_flag,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic [2:0] kind,
	input logic       last
);

	// Hold a stalled input item until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(end_flag))
		else $error("stalled input item changed or dropped");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind)
			&& $stable(last))
		else $error("stalled result changed or dropped");

	// Mark last exactly on close and error results
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != KIND_BYTE)))
		else $error("last does not match result kind");

	// Carry a zero byte on close and error results
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BYTE |-> out_byte == 8'h00)
		else $error("status result carries a byte");

	// Produce only defined kinds
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= KIND_UNTERMINATED)
		else $error("undefined result kind");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_byte   (in_byte),
	.end_flag  (end_flag),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.kind      (kind),
	.last      (last)
);
